// ===== hdl/trs_pkg.sv =====
// Package for the tip-over recovery sequencer: request/result structs,
// phase, operation and register index codes, reset defaults.
// No dependencies.
`default_nettype none

package trs_pkg;

  // Default width of the elapsed-tick counters
  localparam int TICK_COUNTER_BITS_DEF = 16;

  // Phase codes
  localparam logic [1:0] PH_DETECT = 2'd0;
  localparam logic [1:0] PH_ROLL   = 2'd1;
  localparam logic [1:0] PH_BEND   = 2'd2;
  localparam logic [1:0] PH_CHECK  = 2'd3;

  // Side codes from the tilt sensor
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_LEFT  = 2'd2;

  // Request operations
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Config register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_UPDATE_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROLL_TIME       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BEND_TIME       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHECK_TIME      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RETRY_LIMIT     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_STEER       = 3'd5;
  localparam int CFG_DATA_BITS = 16;

  // Register reset values
  localparam logic [15:0] UPDATE_INTERVAL_RST = 16'd10;
  localparam logic [15:0] ROLL_TIME_RST       = 16'd1000;
  localparam logic [15:0] BEND_TIME_RST       = 16'd1000;
  localparam logic [15:0] CHECK_TIME_RST      = 16'd1000;
  localparam logic [7:0]  RETRY_LIMIT_RST     = 8'd3;
  localparam logic [14:0] MAX_STEER_RST       = 15'h7FFF;

  localparam logic [6:0] FULL_POWER  = 7'd100;
  localparam logic [7:0] RETRY_MAX   = 8'hFF;

  typedef struct packed {
    logic       operation;
    logic       on_side;
    logic [1:0] side_dir;
  } req_t;

  typedef struct packed {
    logic [6:0]         motor_power;
    logic               wrap_cmd;
    logic signed [15:0] steer_cmd;
    logic [1:0]         phase;
    logic               running;
    logic               succeeded;
    logic [7:0]         retries;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/tipover_recovery_sequencer.sv =====
// Top level of the tip-over recovery sequencer: request register, phase
// sequencer logic, result register and config registers.
// Depends on trs_pkg.
`default_nettype none

// Tip-over recovery sequencer. Each request is either a start (re-arms the
// sequence, clears phase, retry and tick counters) or a tick carrying the
// tilt sensor's on-side flag and side direction. Ticks are counted while
// running; the phase logic acts only when the ticks since its last action
// reach update_interval. Phases: detect (latch side), roll (full power),
// bend roll (full power, steer toward the latched side), check (arm wrap,
// then judge upright after check_time). Every request returns exactly one
// result carrying the held commands and status after that request.
// Throughput is one request per clock unless rsp_ready stalls the result;
// the result is registered after the request is accepted (request register,
// then the sequencer step into the result register). State updates per step,
// so consecutive ticks need no spacing. Config writes are always ready and
// must be issued only while no request is in flight.
module tipover_recovery_sequencer #(
  parameter int TICK_COUNTER_BITS = trs_pkg::TICK_COUNTER_BITS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst,
  // request channel
  input  wire                                    req_valid,
  output logic                                   req_ready,
  input  trs_pkg::req_t                          req_data,
  // result channel
  output logic                                   rsp_valid,
  input  wire                                    rsp_ready,
  output trs_pkg::rsp_t                          rsp_data,
  // config write channel
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [trs_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  wire  [trs_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import trs_pkg::*;

  // compare width covers both the counters and the 16-bit time registers
  localparam int CMP_W = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;
  localparam logic [TICK_COUNTER_BITS-1:0] TICK_MAX = '1;

  // config registers
  logic [15:0] update_interval, roll_time, bend_time, check_time;
  logic [7:0]  retry_limit;
  logic [14:0] max_steer;

  // request register
  logic s1_valid;
  req_t s1_req;

  // sequencer state
  logic [1:0]                   phase, phase_next;
  logic [1:0]                   latched_side, latched_side_next;
  logic                         check_started, check_started_next;
  logic [7:0]                   retry_count, retry_count_next;
  logic [TICK_COUNTER_BITS-1:0] phase_ticks, phase_ticks_next;
  logic [TICK_COUNTER_BITS-1:0] update_ticks, update_ticks_next;
  logic                         active, active_next;
  logic                         success_flag, success_flag_next;
  logic [6:0]                   motor_hold, motor_hold_next;
  logic                         wrap_hold, wrap_hold_next;
  logic signed [15:0]           steer_hold, steer_hold_next;

  logic                         advance;
  logic [TICK_COUNTER_BITS-1:0] ut_inc, pt_inc, pt_chk;
  logic [1:0]                   ph_eff;
  logic signed [15:0]           steer_pos, steer_neg;

  // result register frees the request stage whenever it is empty or drained
  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  assign ut_inc = (update_ticks == TICK_MAX) ? update_ticks
                                             : update_ticks + TICK_COUNTER_BITS'(1);
  assign pt_inc = (phase_ticks == TICK_MAX) ? phase_ticks
                                            : phase_ticks + TICK_COUNTER_BITS'(1);
  assign steer_pos = {1'b0, max_steer};
  assign steer_neg = -steer_pos;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      update_interval <= UPDATE_INTERVAL_RST;
      roll_time       <= ROLL_TIME_RST;
      bend_time       <= BEND_TIME_RST;
      check_time      <= CHECK_TIME_RST;
      retry_limit     <= RETRY_LIMIT_RST;
      max_steer       <= MAX_STEER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_UPDATE_INTERVAL: update_interval <= cfg_data;
        REG_ROLL_TIME:       roll_time       <= cfg_data;
        REG_BEND_TIME:       bend_time       <= cfg_data;
        REG_CHECK_TIME:      check_time      <= cfg_data;
        REG_RETRY_LIMIT:     retry_limit     <= cfg_data[7:0];
        REG_MAX_STEER:       max_steer       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // one sequencer step for the registered request
  always_comb begin
    phase_next         = phase;
    latched_side_next  = latched_side;
    check_started_next = check_started;
    retry_count_next   = retry_count;
    phase_ticks_next   = phase_ticks;
    update_ticks_next  = update_ticks;
    active_next        = active;
    success_flag_next  = success_flag;
    motor_hold_next    = motor_hold;
    wrap_hold_next     = wrap_hold;
    steer_hold_next    = steer_hold;
    ph_eff             = phase;
    pt_chk             = pt_inc;

    if (s1_req.operation == OP_START) begin
      // start keeps the held commands
      phase_next         = PH_DETECT;
      check_started_next = 1'b0;
      retry_count_next   = '0;
      phase_ticks_next   = '0;
      update_ticks_next  = '0;
      active_next        = 1'b1;
      success_flag_next  = 1'b0;
    end else if (active) begin
      update_ticks_next = ut_inc;
      phase_ticks_next  = pt_inc;
      if (CMP_W'(ut_inc) >= CMP_W'(update_interval)) begin
        update_ticks_next = '0;
        // upright outside check jumps straight to check
        if (!s1_req.on_side && phase != PH_CHECK) begin
          ph_eff = PH_CHECK;
        end
        phase_next = ph_eff;
        case (ph_eff)
          PH_DETECT: begin
            motor_hold_next   = '0;
            wrap_hold_next    = 1'b0;
            steer_hold_next   = '0;
            latched_side_next = s1_req.side_dir;
            phase_next        = PH_ROLL;
            phase_ticks_next  = '0;
          end
          PH_ROLL: begin
            wrap_hold_next  = 1'b0;
            steer_hold_next = '0;
            motor_hold_next = FULL_POWER;
            if (CMP_W'(pt_inc) > CMP_W'(roll_time)) begin
              phase_next       = PH_BEND;
              phase_ticks_next = '0;
            end
          end
          PH_BEND: begin
            motor_hold_next = FULL_POWER;
            wrap_hold_next  = 1'b0;
            // no latched side: steering holds
            if (latched_side == SIDE_RIGHT) begin
              steer_hold_next = steer_neg;
            end else if (latched_side == SIDE_LEFT) begin
              steer_hold_next = steer_pos;
            end
            if (CMP_W'(pt_inc) > CMP_W'(bend_time)) begin
              motor_hold_next  = '0;
              steer_hold_next  = '0;
              phase_next       = PH_CHECK;
              phase_ticks_next = '0;
            end
          end
          default: begin
            if (!check_started) begin
              pt_chk             = '0;
              phase_ticks_next   = '0;
              motor_hold_next    = '0;
              steer_hold_next    = '0;
              wrap_hold_next     = 1'b1;
              check_started_next = 1'b1;
            end
            if (CMP_W'(pt_chk) > CMP_W'(check_time)) begin
              if (!s1_req.on_side) begin
                active_next       = 1'b0;
                success_flag_next = 1'b1;
                motor_hold_next   = '0;
              end else begin
                if (retry_count != RETRY_MAX) begin
                  retry_count_next = retry_count + 8'd1;
                end
                if (retry_count >= retry_limit) begin
                  // give up
                  active_next       = 1'b0;
                  success_flag_next = 1'b0;
                  motor_hold_next   = '0;
                end else begin
                  phase_next         = PH_DETECT;
                  phase_ticks_next   = '0;
                  check_started_next = 1'b0;
                end
              end
            end
          end
        endcase
      end
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_req <= req_data;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DETECT;
      latched_side  <= '0;
      check_started <= 1'b0;
      retry_count   <= '0;
      phase_ticks   <= '0;
      update_ticks  <= '0;
      active        <= 1'b0;
      success_flag  <= 1'b0;
      motor_hold    <= '0;
      wrap_hold     <= 1'b0;
      steer_hold    <= '0;
      rsp_valid     <= 1'b0;
    end else if (s1_valid && advance) begin
      phase         <= phase_next;
      latched_side  <= latched_side_next;
      check_started <= check_started_next;
      retry_count   <= retry_count_next;
      phase_ticks   <= phase_ticks_next;
      update_ticks  <= update_ticks_next;
      active        <= active_next;
      success_flag  <= success_flag_next;
      motor_hold    <= motor_hold_next;
      wrap_hold     <= wrap_hold_next;
      steer_hold    <= steer_hold_next;
      rsp_valid     <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      rsp_data.motor_power <= motor_hold_next;
      rsp_data.wrap_cmd    <= wrap_hold_next;
      rsp_data.steer_cmd   <= steer_hold_next;
      rsp_data.phase       <= phase_next;
      rsp_data.running     <= active_next;
      rsp_data.succeeded   <= success_flag_next;
      rsp_data.retries     <= retry_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/trs_checker.sv =====
// Port-level checker for the tip-over recovery sequencer, bound to the top.
// Depends on trs_pkg and tipover_recovery_sequencer.
`default_nettype none

module trs_checker (
  input wire           clk,
  input wire           rst,
  input wire           rsp_valid,
  input wire           rsp_ready,
  input trs_pkg::rsp_t rsp_data
);
  import trs_pkg::*;

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a finished or idle sequence drives no motor
  a_idle_motor: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.running |-> rsp_data.motor_power == 7'd0)
    else $error("motor on while not running");

  // success is only reported from check, after the run has ended
  a_success: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.succeeded |-> !rsp_data.running && rsp_data.phase == PH_CHECK)
    else $error("success outside a finished check");

endmodule

bind tipover_recovery_sequencer trs_checker u_trs_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

`default_nettype wire
